// ===== rtl/sthi_pkg.sv =====
// Shared types and constants for the service tuple hash index.
package sthi_pkg;

    localparam int BUCKETS = 2048;
    localparam int ENTRIES = 1024;
    localparam int BKT_W = $clog2(BUCKETS);
    localparam int ENT_W = $clog2(ENTRIES);
    localparam int CNT_W = ENT_W + 1;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_MUL = 64'h00000100000001b3;
    // prime = 2^40 + 0x1b3: a 40-bit shift plus a narrow constant multiply
    localparam int          FNV_MUL_SH = 40;
    localparam logic [8:0]  FNV_MUL_LO = 9'h1b3;
    localparam logic [7:0] PROTO_WIDE = 8'd41;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // Hash sequence: bytes of a 64-byte frame, gaps skipped for short addresses.
    localparam int HB_W = 6;

    typedef struct packed {
        logic        req_type;
        logic [63:0] vip_hi;
        logic [63:0] vip_lo;
        logic [7:0]  vip_family;
        logic [63:0] real_hi;
        logic [63:0] real_lo;
        logic [7:0]  real_proto;
        logic [15:0] port;
        logic [7:0]  l4_proto;
        logic [15:0] svc_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_idx;
    } rsp_t;

    typedef struct packed {
        logic [63:0]      vip_hi;
        logic [63:0]      vip_lo;
        logic [63:0]      real_hi;
        logic [63:0]      real_lo;
        logic [39:0]      meta;
        logic [15:0]      service;
        logic             next_vld;
        logic [ENT_W-1:0] next;
    } rec_t;

    typedef struct packed {
        logic             vld;
        logic [ENT_W-1:0] ent;
    } head_t;

endpackage

// ===== rtl/sthi_ram.sv =====
// Generic single-port RAM with registered read.
module sthi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/sthi_hash.sv =====
// Byte-serial FNV-1a 64 hash unit over the request key.
module sthi_hash (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  sthi_pkg::req_t  req,
    output logic            done,
    output logic [sthi_pkg::BKT_W-1:0] bucket
);
    import sthi_pkg::*;

    // Frame bytes: vip 0..15, vproto 16..23, real 24..39, rproto 40..47,
    // port 48..55, tproto 56..63.
    logic [HB_W-1:0] pos_reg, pos_next;
    logic            run_reg, run_next;
    logic            done_reg;
    logic [63:0]     h_reg, h_next;
    logic [63:0]     mix;
    logic [7:0]      byte_sel;
    logic [511:0]    frame;
    logic            vw, rw;
    logic            last;

    assign vw = (req.vip_family == PROTO_WIDE);
    assign rw = (req.real_proto == PROTO_WIDE);

    always_comb
    begin
        frame = {req.vip_hi, req.vip_lo,
                 56'd0, req.vip_family,
                 req.real_hi, req.real_lo,
                 56'd0, req.real_proto,
                 48'd0, req.port,
                 56'd0, req.l4_proto};
        // address bytes in order, protocol words little endian
        if (pos_reg[5:3] inside {3'd0, 3'd1, 3'd3, 3'd4})
        begin
            byte_sel = frame[511 - 8 * int'(pos_reg) -: 8];
        end
        else
        begin
            byte_sel = frame[511 - 8 * int'({pos_reg[5:3], 3'b111 - pos_reg[2:0]}) -: 8];
        end
    end

    assign last = (pos_reg == 6'd63);
    assign mix  = h_reg ^ {56'd0, byte_sel};

    always_comb
    begin
        run_next = run_reg;
        pos_next = pos_reg;
        h_next   = h_reg;
        if (go)
        begin
            run_next = 1'b1;
            pos_next = '0;
            h_next   = FNV_BASIS;
        end
        else if (run_reg)
        begin
            h_next = (mix << FNV_MUL_SH) + mix * FNV_MUL_LO;
            if (last)
            begin
                run_next = 1'b0;
            end
            else if (pos_reg == 6'd3 && !vw)
            begin
                pos_next = 6'd16;
            end
            else if (pos_reg == 6'd27 && !rw)
            begin
                pos_next = 6'd40;
            end
            else
            begin
                pos_next = pos_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= run_reg && last;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
    end

    assign done   = done_reg;
    assign bucket = h_reg[BKT_W-1:0];

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("hash done held");
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(run_reg)) else $error("hash done without run");
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> !run_reg) else $error("hash restarted while running");

endmodule

// ===== rtl/service_tuple_hash_index.sv =====
// Top level of the service tuple hash index: sequencer, bucket and entry stores.
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------
//  request  | start / busy     | req  (sthi_pkg::req_t)
//  result   | done strobe      | rsp  (sthi_pkg::rsp_t)
//
// The hash mixes one key byte per cycle through the shared multiply-add: 40
// bytes with two short addresses, 52 with one wide, 64 with both. A full pool
// is answered as soon as the hash is done; an insert or a lookup first reads
// the bucket head, and a lookup that finds a valid head then walks the chain,
// one registered entry read per entry, until a hit or the end of the chain.
// After reset the bucket-head RAM is cleared, one bucket per cycle, with busy
// high. The result strobe lasts one cycle; the receiver cannot stall, so busy
// falls as the strobe is given.
module service_tuple_hash_index (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  sthi_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output sthi_pkg::rsp_t rsp
);
    import sthi_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_HEAD  = 7'b0001000,
        S_HWAIT = 7'b0010000,
        S_ENT   = 7'b0100000,
        S_EWAIT = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    req_t             req_reg;
    logic [BKT_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [ENT_W-1:0] cur_reg, cur_next;
    logic             done_reg, done_next;
    rsp_t             rsp_reg, rsp_next;

    logic             hash_go, hash_done;
    logic [BKT_W-1:0] bucket;

    logic             h_we;
    logic [BKT_W-1:0] h_addr;
    head_t            h_wdata, h_rdata;
    logic             e_we;
    logic [ENT_W-1:0] e_addr;
    rec_t             e_wdata, e_rdata;

    logic [39:0]      meta;
    logic             vw, rw, hit;

    assign hash_go = (state_reg == S_IDLE) && start;

    sthi_hash u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (hash_go),
        .req    (start && state_reg == S_IDLE ? req : req_reg),
        .done   (hash_done),
        .bucket (bucket)
    );

    sthi_ram #(.WIDTH($bits(head_t)), .DEPTH(BUCKETS)) u_head_ram (
        .clk   (clk),
        .we    (h_we),
        .addr  (h_addr),
        .wdata (h_wdata),
        .rdata (h_rdata)
    );

    sthi_ram #(.WIDTH($bits(rec_t)), .DEPTH(ENTRIES)) u_ent_ram (
        .clk   (clk),
        .we    (e_we),
        .addr  (e_addr),
        .wdata (e_wdata),
        .rdata (e_rdata)
    );

    assign meta = {req_reg.l4_proto, req_reg.port, req_reg.real_proto,
                   req_reg.vip_family};
    assign vw = (req_reg.vip_family == PROTO_WIDE);
    assign rw = (req_reg.real_proto == PROTO_WIDE);

    // key compare against the entry just read
    assign hit = (e_rdata.meta == meta)
        && (e_rdata.vip_hi[63:32] == req_reg.vip_hi[63:32])
        && (!vw || (e_rdata.vip_hi[31:0] == req_reg.vip_hi[31:0]
                    && e_rdata.vip_lo == req_reg.vip_lo))
        && (e_rdata.real_hi[63:32] == req_reg.real_hi[63:32])
        && (!rw || (e_rdata.real_hi[31:0] == req_reg.real_hi[31:0]
                    && e_rdata.real_lo == req_reg.real_lo));

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        used_next  = used_reg;
        steps_next = steps_reg;
        cur_next   = cur_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        h_we       = 1'b0;
        h_addr     = bucket;
        h_wdata    = '0;
        e_we       = 1'b0;
        e_addr     = cur_reg;
        e_wdata    = '0;
        case (state_reg)
            S_CLEAR:
            begin
                h_we   = 1'b1;
                h_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    if (req_reg.req_type == REQ_INSERT && used_reg == CNT_W'(ENTRIES))
                    begin
                        rsp_next   = '{status: ST_FULL, found_idx: 16'd0};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                // head read issued at bucket address
                state_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (req_reg.req_type == REQ_INSERT)
                begin
                    e_we   = 1'b1;
                    e_addr = used_reg[ENT_W-1:0];
                    e_wdata = '{vip_hi: req_reg.vip_hi, vip_lo: req_reg.vip_lo,
                                real_hi: req_reg.real_hi, real_lo: req_reg.real_lo,
                                meta: meta, service: req_reg.svc_index,
                                next_vld: h_rdata.vld, next: h_rdata.ent};
                    h_we    = 1'b1;
                    h_wdata = '{vld: 1'b1, ent: used_reg[ENT_W-1:0]};
                    used_next  = used_reg + 1'b1;
                    rsp_next   = '{status: ST_OK, found_idx: 16'd0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!h_rdata.vld)
                begin
                    rsp_next   = '{status: ST_MISS, found_idx: 16'd0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next   = h_rdata.ent;
                    steps_next = '0;
                    state_next = S_ENT;
                end
            end
            S_ENT:
            begin
                state_next = S_EWAIT;
            end
            S_EWAIT:
            begin
                steps_next = steps_reg + 1'b1;
                if (hit)
                begin
                    rsp_next   = '{status: ST_OK, found_idx: e_rdata.service};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!e_rdata.next_vld || steps_next == CNT_W'(ENTRIES))
                begin
                    rsp_next   = '{status: ST_MISS, found_idx: 16'd0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next   = e_rdata.next;
                    state_next = S_ENT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg <= steps_next;
        cur_reg   <= cur_next;
        rsp_reg   <= rsp_next;
        if (hash_go)
        begin
            req_reg <= req;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(ENTRIES)) else $error("entry count overrun");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE) else $error("result while busy");
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == ST_FULL |-> used_reg == CNT_W'(ENTRIES))
        else $error("full reported with free entries");
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != $past(used_reg) |-> $past(state_reg) == S_HWAIT)
        else $error("entry count moved outside insert");

endmodule

// ===== tb/sv/sthi_index_monitor.sv =====
// Watches the service tuple hash index channels, predicts each result and compares.
module sthi_index_monitor (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  sthi_pkg::req_t req,
    input  logic           done,
    input  sthi_pkg::rsp_t rsp,
    output int             errors,
    output int             outstanding
);
    import sthi_pkg::*;

    // mirror of the chained store
    logic             head_vld [BUCKETS];
    logic [ENT_W-1:0] head_ent [BUCKETS];
    logic             link_vld [ENTRIES];
    logic [ENT_W-1:0] link_ent [ENTRIES];
    req_t             stored_key [ENTRIES];
    logic [CNT_W-1:0] used;
    rsp_t             awaited_rsp [$];

    function automatic logic [63:0] fnv_byte(logic [63:0] h, logic [7:0] b);
        return (h ^ {56'd0, b}) * FNV_MUL;
    endfunction

    function automatic logic [63:0] fnv_addr(logic [63:0] h, logic [63:0] hi,
                                             logic [63:0] lo, logic wide);
        for (int i = 0; i < 8; i++)
            if (i < 4 || wide)
                h = fnv_byte(h, hi[63 - 8 * i -: 8]);
        if (wide)
            for (int i = 0; i < 8; i++)
                h = fnv_byte(h, lo[63 - 8 * i -: 8]);
        return h;
    endfunction

    // little-endian 8-byte word, value up to 16 bits
    function automatic logic [63:0] fnv_word(logic [63:0] h, logic [15:0] v);
        h = fnv_byte(h, v[7:0]);
        h = fnv_byte(h, v[15:8]);
        for (int i = 0; i < 6; i++)
            h = fnv_byte(h, 8'd0);
        return h;
    endfunction

    function automatic logic addr_same(logic [63:0] ahi, logic [63:0] alo,
                                       logic [63:0] bhi, logic [63:0] blo, logic wide);
        if (wide)
            return ahi == bhi && alo == blo;
        return ahi[63:32] == bhi[63:32];
    endfunction

    function automatic logic key_same(req_t a, req_t b);
        logic vw;
        logic rw;
        vw = b.vip_family == PROTO_WIDE;
        rw = b.real_proto == PROTO_WIDE;
        return a.vip_family == b.vip_family && a.real_proto == b.real_proto
            && a.port == b.port && a.l4_proto == b.l4_proto
            && addr_same(a.vip_hi, a.vip_lo, b.vip_hi, b.vip_lo, vw)
            && addr_same(a.real_hi, a.real_lo, b.real_hi, b.real_lo, rw);
    endfunction

    function automatic rsp_t insert_or_lookup(req_t r);
        logic [63:0]      h;
        logic [BKT_W-1:0] b;
        rsp_t             res;
        logic             have;
        logic [ENT_W-1:0] e;
        int               steps;
        h = FNV_BASIS;
        h = fnv_addr(h, r.vip_hi, r.vip_lo, r.vip_family == PROTO_WIDE);
        h = fnv_word(h, {8'd0, r.vip_family});
        h = fnv_addr(h, r.real_hi, r.real_lo, r.real_proto == PROTO_WIDE);
        h = fnv_word(h, {8'd0, r.real_proto});
        h = fnv_word(h, r.port);
        h = fnv_word(h, {8'd0, r.l4_proto});
        b = h[BKT_W-1:0];
        res = '0;
        if (r.req_type == REQ_INSERT)
        begin
            if (used >= ENTRIES)
            begin
                res.status = ST_FULL;
                return res;
            end
            e = used[ENT_W-1:0];
            stored_key[e] = r;
            link_vld[e] = head_vld[b];
            link_ent[e] = head_ent[b];
            head_vld[b] = 1'b1;
            head_ent[b] = e;
            used = used + 1'b1;
            res.status = ST_OK;
            return res;
        end
        have = head_vld[b];
        e = head_ent[b];
        steps = 0;
        while (have && steps < ENTRIES)
        begin
            if (key_same(stored_key[e], r))
            begin
                res.status = ST_OK;
                res.found_idx = stored_key[e].svc_index;
                return res;
            end
            have = link_vld[e];
            e = link_ent[e];
            steps++;
        end
        res.status = ST_MISS;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
                head_vld[i] = 1'b0;
            used = '0;
            awaited_rsp.delete();
            errors <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result transfer: %p", rsp);
                    errors <= errors + 1;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.status !== want.status || rsp.found_idx !== want.found_idx)
                    begin
                        if (errors < 10)
                            $display("result mismatch: expected status %0d idx %h, got %0d %h",
                                     want.status, want.found_idx, rsp.status, rsp.found_idx);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                awaited_rsp.push_back(insert_or_lookup(req));
            outstanding <= awaited_rsp.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Stimulus and verdict for the service tuple hash index.
module testbench;
    import sthi_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;
    int   errors;
    int   outstanding;

    // keys reused by many requests so chains grow and duplicates shadow
    req_t key_pool [48];
    int   idle_left;
    logic idling_on;
    int   quiet_cycles;

    service_tuple_hash_index dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    sthi_index_monitor mon (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // wide (41), plain IPv4-ish (4) or any other protocol number
    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 3))
            0, 1:    return PROTO_WIDE;
            2:       return 8'd4;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic req_t random_key();
        req_t k;
        k = '0;
        k.vip_hi = rand64();
        k.vip_lo = rand64();
        k.vip_family = pick_proto();
        k.real_hi = rand64();
        k.real_lo = rand64();
        k.real_proto = pick_proto();
        k.port = 16'($urandom);
        k.l4_proto = 8'($urandom);
        k.svc_index = 16'($urandom);
        return k;
    endfunction

    // bytes outside a short address are ignored, so scramble them on lookups
    function automatic req_t scramble_ignored(req_t k);
        if (k.vip_family != PROTO_WIDE)
        begin
            k.vip_lo = rand64();
            k.vip_hi[31:0] = $urandom;
        end
        if (k.real_proto != PROTO_WIDE)
        begin
            k.real_lo = rand64();
            k.real_hi[31:0] = $urandom;
        end
        return k;
    endfunction

    // Idling comes in bursts; the gap before each transfer is drawn here.
    function automatic int next_gap();
        if (idle_left == 0)
        begin
            idling_on = ($urandom_range(0, 2) == 0);
            idle_left = $urandom_range(1, 18);
            return idling_on ? idle_left : 0;
        end
        idle_left--;
        return 0;
    endfunction

    // One request transfer: optional gap, then hold start until busy is low.
    task automatic send(req_t r, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_op(req_t r, logic op, int gap);
        r.req_type = op;
        send(r, gap);
    endtask

    // Watchdog: cycles with no transfer on either channel.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 20000)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        req_t k;
        req_t dup;
        int   pick;
        start = 1'b0;
        req = '0;
        rst_n = 1'b0;
        idle_left = 0;
        idling_on = 1'b0;
        for (int i = 0; i < 48; i++)
            key_pool[i] = random_key();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty store, extremes, shadowing, ignored bytes
        k = '0;
        send_op(k, REQ_LOOKUP, 0);
        send_op(k, REQ_INSERT, 0);
        send_op(k, REQ_LOOKUP, 0);
        k = '1;
        send_op(k, REQ_LOOKUP, 0);
        send_op(k, REQ_INSERT, 0);
        send_op(k, REQ_LOOKUP, 3);
        k.vip_family = PROTO_WIDE;
        k.real_proto = PROTO_WIDE;
        send_op(k, REQ_INSERT, 0);
        k.svc_index = 16'h0000;
        send_op(k, REQ_LOOKUP, 0);
        k.vip_lo[0] = 1'b0;
        send_op(k, REQ_LOOKUP, 0);
        // duplicate key: the newer entry must win
        dup = key_pool[0];
        dup.vip_family = 8'd4;
        dup.real_proto = PROTO_WIDE;
        send_op(dup, REQ_INSERT, 0);
        dup.svc_index = ~dup.svc_index;
        send_op(dup, REQ_INSERT, 1);
        send_op(scramble_ignored(dup), REQ_LOOKUP, 0);
        dup.real_lo = ~dup.real_lo;
        send_op(dup, REQ_LOOKUP, 0);
        dup = key_pool[1];
        dup.vip_family = PROTO_WIDE;
        dup.real_proto = 8'd0;
        dup.port = 16'hffff;
        send_op(dup, REQ_INSERT, 0);
        send_op(scramble_ignored(dup), REQ_LOOKUP, 0);
        dup.port = 16'h0000;
        send_op(dup, REQ_LOOKUP, 0);
        dup.l4_proto = 8'hff;
        send_op(dup, REQ_INSERT, 2);
        send_op(dup, REQ_LOOKUP, 0);

        // random: mostly pool keys, some noise
        for (int n = 0; n < 820; n++)
        begin
            pick = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, 47)];
            if (pick < 45)
            begin
                k.svc_index = 16'($urandom);
                send_op(k, REQ_INSERT, next_gap());
            end
            else if (pick < 85)
            begin
                send_op(scramble_ignored(k), REQ_LOOKUP, next_gap());
            end
            else if (pick < 95)
            begin
                send_op(random_key(), REQ_LOOKUP, next_gap());
            end
            else
            begin
                send_op(random_key(), REQ_INSERT, next_gap());
            end
        end

        // last part, no idling: inserts and lookups back to back
        for (int n = 0; n < 60; n++)
        begin
            k = key_pool[$urandom_range(0, 47)];
            if ($urandom_range(0, 1) == 0)
            begin
                k.svc_index = 16'($urandom);
                send_op(k, REQ_INSERT, 0);
            end
            else
            begin
                send_op(scramble_ignored(k), REQ_LOOKUP, 0);
            end
        end
        start <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sthi_pkg.sv
rtl/sthi_ram.sv
rtl/sthi_hash.sv
rtl/service_tuple_hash_index.sv
tb/sv/sthi_index_monitor.sv
tb/sv/testbench.sv
